/* hw/rtl/wrr_pkg.sv */
// ----------------------------------------------------------------------------
// wrr_pkg: weighted round-robin select package
// Field widths, action codes and the request/result payload types.
// ----------------------------------------------------------------------------
package wrr_pkg;

  localparam int MAX_SERVERS_DEF = 16;
  localparam int WEIGHT_BITS_DEF = 8;

  localparam int ACTION_W  = 1;
  localparam int INDEX_W   = 4;
  localparam int WEIGHT_W  = 8;
  localparam int COUNT_W   = 5;

  localparam logic [ACTION_W-1:0] ACT_WRITE  = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_SELECT = 1'b1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  entry_index;
    logic [WEIGHT_W-1:0] entry_weight;
  } request_t;

  typedef struct packed {
    logic [INDEX_W-1:0] server_index;
    logic               found;
  } result_t;

endpackage

/* hw/rtl/weighted_round_robin_select.sv */
// ----------------------------------------------------------------------------
// weighted_round_robin_select: interleaved weighted round-robin selector
// Weight table with write and select requests; gcd-stepped current weight.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                         payload
//  -------   ---  --------------------------------  -------------------------
//  request   in   request_valid / request_stall     request_t (action, index,
//                                                    weight)
//  result    out  result_valid / result_stall       result_t (index, found)
//  config    in   cfg_write_enable                  cfg_write_data (count)
//
//  Write request: updates a table entry, no result.
//  Select request: per table entry in use a read (S_SCAN_RD), a load
//  (S_SCAN_LD) and binary gcd steps (S_GCD), then S_SCAN_END to close the
//  scan, then a position step (S_STEP) and a check (S_CHECK) per step (at
//  most 2*MAX_SERVERS+4 steps), with S_REDUCE on a wrap that lowers the
//  current weight, held for each extra gcd subtraction of a stale weight,
//  and the done flag to hand off the result. A select with a zero count
//  skips the scan and goes straight to the hand-off.
//  request_stall is high for the whole select; a finished select whose result
//  cannot leave holds done, and with it request_stall, until result_stall
//  drops.
//  Reset (rst, synchronous) clears the entry valid bits at once: no sweep.
//
module weighted_round_robin_select
  import wrr_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  logic [COUNT_W-1:0] cfg_write_data,
  input  logic               request_valid,
  output logic               request_stall,
  input  request_t           request,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result
);

  localparam int ADDR_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
  localparam int KW     = $clog2(WEIGHT_BITS + 1);
  localparam int LIMIT  = 2 * MAX_SERVERS + 4;
  localparam int SW     = $clog2(LIMIT);
  localparam int W      = WEIGHT_BITS;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN_RD  = 8'b0000_0010,
    S_SCAN_LD  = 8'b0000_0100,
    S_GCD      = 8'b0000_1000,
    S_SCAN_END = 8'b0001_0000,
    S_STEP     = 8'b0010_0000,
    S_REDUCE   = 8'b0100_0000,
    S_CHECK    = 8'b1000_0000
  } state_t;

  // hand-off of a finished select is folded into a flag so the FSM stays small
  state_t             state;
  logic               done;
  logic [COUNT_W-1:0] server_count;
  logic [CNT_W-1:0]   n_cnt;
  logic [ADDR_W-1:0]  scan_idx;
  logic [W-1:0]       top_wt;
  logic [W-1:0]       gcd_val;
  logic [W-1:0]       ga;
  logic [W-1:0]       gb;
  logic [KW-1:0]      gk;
  logic [ADDR_W-1:0]  position;
  logic [W-1:0]       cur_wt;
  logic [SW-1:0]      step_cnt;
  result_t            res;

  // weight table: memory plus one valid bit per entry (unwritten reads as 0)
  logic [W-1:0]           mem [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] entry_valid;
  logic [W-1:0]           rd_data;
  logic                   rd_valid;
  logic [ADDR_W-1:0]      rd_addr;
  logic [W-1:0]           rd_weight;

  logic               req_accept;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [CNT_W-1:0]   n_sat;
  logic [CNT_W-1:0]   pos_inc;
  logic [ADDR_W-1:0]  pos_n;
  logic               out_free;

  // shared subtract/compare unit
  logic [W-1:0]       op_a;
  logic [W-1:0]       op_b;
  logic [W:0]         diff;
  logic               a_ge_b;
  logic [W-1:0]       abs_diff;

  assign request_stall = (state != S_IDLE) || done;
  assign req_accept    = request_valid && !request_stall;
  assign wr_en         = req_accept && (request.action == ACT_WRITE) &&
                         (32'(request.entry_index) < MAX_SERVERS);
  assign wr_addr       = ADDR_W'(request.entry_index);
  assign out_free      = !result_valid || !result_stall;

  // count above the table size saturates
  assign n_sat = (32'(server_count) > MAX_SERVERS) ? CNT_W'(MAX_SERVERS)
                                                   : CNT_W'(server_count);

  // position step with wrap; a stale position past the count wraps too
  assign pos_inc = CNT_W'(position) + CNT_W'(1);
  assign pos_n   = (pos_inc >= n_cnt) ? '0 : ADDR_W'(pos_inc);

  always_comb begin
    if (state == S_SCAN_RD) begin
      rd_addr = scan_idx;
    end else if (state == S_STEP) begin
      rd_addr = pos_n;
    end else begin
      rd_addr = position;
    end
  end

  always_comb begin
    if (state == S_GCD) begin
      op_a = ga;
      op_b = gb;
    end else begin
      op_a = cur_wt;
      op_b = gcd_val;
    end
  end

  assign diff      = {1'b0, op_a} - {1'b0, op_b};
  assign a_ge_b    = !diff[W];
  assign abs_diff  = a_ge_b ? diff[W-1:0] : W'(-diff);
  assign rd_weight = rd_valid ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= W'(request.entry_weight);
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      rd_valid <= entry_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= COUNT_W'(1);
    end else if (cfg_write_enable) begin
      server_count <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      result_valid <= 1'b0;
      position     <= ADDR_W'(MAX_SERVERS - 1);
      cur_wt       <= '0;
    end else begin
      if (done && out_free) begin
        result_valid <= 1'b1;
        result       <= res;
        done         <= 1'b0;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_accept && (request.action == ACT_SELECT)) begin
            if (server_count == '0) begin
              res  <= '0;
              done <= 1'b1;
            end else begin
              n_cnt    <= n_sat;
              scan_idx <= '0;
              top_wt   <= '0;
              gcd_val  <= '0;
              state    <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_LD;
        end
        S_SCAN_LD: begin
          if (rd_weight > top_wt) begin
            top_wt <= rd_weight;
          end
          ga    <= gcd_val;
          gb    <= rd_weight;
          gk    <= '0;
          state <= S_GCD;
        end
        S_GCD: begin
          // binary gcd, one step a cycle
          if (ga == '0 || gb == '0) begin
            gcd_val <= (ga == '0) ? W'(gb << gk) : W'(ga << gk);
            if (CNT_W'(scan_idx) + CNT_W'(1) == n_cnt) begin
              state <= S_SCAN_END;
            end else begin
              scan_idx <= scan_idx + ADDR_W'(1);
              state    <= S_SCAN_RD;
            end
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            gk <= gk + KW'(1);
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (a_ge_b) begin
            ga <= abs_diff >> 1;
          end else begin
            gb <= abs_diff >> 1;
          end
        end
        S_SCAN_END: begin
          if (top_wt == '0) begin
            position <= '0;
            cur_wt   <= '0;
            res      <= '0;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            step_cnt <= '0;
            state    <= S_STEP;
          end
        end
        S_STEP: begin
          position <= pos_n;
          if (pos_n == '0) begin
            if (!a_ge_b || diff[W-1:0] == '0) begin
              cur_wt <= top_wt;
              state  <= S_CHECK;
            end else begin
              cur_wt <= diff[W-1:0];
              state  <= S_REDUCE;
            end
          end else begin
            state <= S_CHECK;
          end
        end
        S_REDUCE: begin
          // stale weight: drop by gcd until it is within the greatest weight
          if (cur_wt > top_wt) begin
            cur_wt <= diff[W-1:0];
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rd_weight >= cur_wt) begin
            res.server_index <= INDEX_W'(position);
            res.found        <= 1'b1;
            done             <= 1'b1;
            state            <= S_IDLE;
          end else if (step_cnt == SW'(LIMIT - 1)) begin
            res   <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            step_cnt <= step_cnt + SW'(1);
            state    <= S_STEP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result only appears out of a finished select
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(done))
    else $error("result_valid rose without a finished select");

  // a select request locks the request side on the next cycle
  a_select_locks: assert property (@(posedge clk) disable iff (rst)
    (req_accept && request.action == ACT_SELECT) |=> request_stall)
    else $error("select request did not stall the request side");

  // a found selection points inside the entries in use
  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && rd_weight >= cur_wt) |-> (CNT_W'(position) < n_cnt))
    else $error("selected position beyond the server count");

  // step counter never runs past the step limit
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (32'(step_cnt) < LIMIT))
    else $error("position step counter overran");

endmodule
